[rtl/bvac_pkg.sv]
// ----------------------------------------------------------------------------
// bvac_pkg
// Word types, register indexes, level codes and constants for the battery
// voltage averager and level classifier.
// ----------------------------------------------------------------------------
package bvac_pkg;

	typedef struct packed {
		logic [15:0] voltage_sample;
		logic        hold;
	} sample_word_t;

	typedef struct packed {
		logic [7:0]  average_voltage;
		logic [2:0]  battery_level;
		logic [15:0] voltage_setpoint;
	} result_word_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESH       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_THRESH    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESH      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ULTRAHIGH_THRESH = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STATUS_OVERRIDE  = 3'd4;

	localparam logic [2:0] LVL_ULTRA_LOW  = 3'd0;
	localparam logic [2:0] LVL_LOW        = 3'd1;
	localparam logic [2:0] LVL_NORMAL     = 3'd2;
	localparam logic [2:0] LVL_HIGH       = 3'd3;
	localparam logic [2:0] LVL_ULTRA_HIGH = 3'd4;
	localparam logic [2:0] NO_OVERRIDE    = 3'd5;

	localparam logic [7:0] LOW_THRESH_RST       = 8'd110;
	localparam logic [7:0] NORMAL_THRESH_RST    = 8'd120;
	localparam logic [7:0] HIGH_THRESH_RST      = 8'd130;
	localparam logic [7:0] ULTRAHIGH_THRESH_RST = 8'd140;

	localparam int AVG_DIVISOR = 160;
	// sums at or above this give an average past 255
	localparam logic [15:0] AVG_SAT_SUM = 16'(256 * AVG_DIVISOR);
	// x / 5 == (x * 52429) >> 18 for all x below 2^16
	localparam logic [15:0] DIV5_RECIP = 16'd52429;
	localparam int          DIV5_SHIFT = 18;

	localparam logic [15:0] SETPOINT_OFFSET = 16'd115;

endpackage

[rtl/bvac_stream_if.sv]
// ----------------------------------------------------------------------------
// bvac_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface bvac_stream_if #(
	parameter type word_t = logic
) ();

	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

[rtl/bvac_ram.sv]
// ----------------------------------------------------------------------------
// bvac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bvac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/battery_voltage_average_classifier.sv]
// ----------------------------------------------------------------------------
// battery_voltage_average_classifier
// Moving average of supply-voltage samples over a ring of WINDOW_DEPTH
// entries, sorted into five battery levels, with a regulator setpoint.
// ----------------------------------------------------------------------------
// A sample word is taken into stage 1, then into the result register.
// Throughput: one word per cycle unless result_ch stalls; the running sum
// is updated as the word is taken; average and level follow in stage 1.
// Reset: every ring entry reads as INITIAL_SAMPLE through per-entry valid
// bits, so no clearing pass; thresholds and override return to defaults.
// ----------------------------------------------------------------------------
module battery_voltage_average_classifier #(
	parameter int WINDOW_DEPTH   = 16,
	parameter int INITIAL_SAMPLE = 1260
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bvac_stream_if.sink                     sample_ch,
	bvac_stream_if.source                   result_ch,
	input  logic                            cfg_we,
	input  logic [bvac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bvac_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bvac_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);
	localparam logic [15:0]      INIT_SAMPLE = 16'(INITIAL_SAMPLE);
	localparam logic [SUM_W-1:0] SUM_RESET   = SUM_W'(WINDOW_DEPTH * INITIAL_SAMPLE);
	localparam logic [SUM_W-1:0] SUM_MAX     = SUM_W'(WINDOW_DEPTH * 65535);
	localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(WINDOW_DEPTH - 1);

	// configuration
	logic [7:0] low_thresh_q;
	logic [7:0] normal_thresh_q;
	logic [7:0] high_thresh_q;
	logic [7:0] ultrahigh_thresh_q;
	logic [2:0] status_override_q;

	// window state
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        idx_d;
	logic [SUM_W-1:0]        sum_q;
	logic [SUM_W-1:0]        sum_d;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [15:0]             ring_rd_data;
	logic [15:0]             old_sample;

	// handshake
	logic in_take;
	logic ring_we;
	logic s1_move;
	logic out_free;

	// stage 1
	logic             v_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [15:0]      sample_s1;

	// result stage
	logic [10:0]  sum_div32;
	logic [26:0]  div5_prod;
	logic [7:0]   avg;
	logic [2:0]   lvl;
	logic [15:0]  setpoint;
	logic         out_v_q;
	result_word_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thresh_q       <= LOW_THRESH_RST;
			normal_thresh_q    <= NORMAL_THRESH_RST;
			high_thresh_q      <= HIGH_THRESH_RST;
			ultrahigh_thresh_q <= ULTRAHIGH_THRESH_RST;
			status_override_q  <= NO_OVERRIDE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_THRESH:       low_thresh_q       <= cfg_data;
				REG_NORMAL_THRESH:    normal_thresh_q    <= cfg_data;
				REG_HIGH_THRESH:      high_thresh_q      <= cfg_data;
				REG_ULTRAHIGH_THRESH: ultrahigh_thresh_q <= cfg_data;
				REG_STATUS_OVERRIDE:  status_override_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign out_free        = !out_v_q || result_ch.ready;
	assign s1_move         = v_s1 && out_free;
	assign sample_ch.ready = !v_s1 || s1_move;
	assign in_take         = sample_ch.valid && sample_ch.ready;
	assign ring_we         = in_take && !sample_ch.data.hold
		&& (sample_ch.data.voltage_sample != 16'd0);

	// RAM is always reading the entry at the next index, so its data
	// matches idx_q; during a write the write address never equals the read address.
	always_comb begin
		idx_d = idx_q;
		if (in_take && !sample_ch.data.hold) begin
			idx_d = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
		end
	end

	assign old_sample = valid_q[idx_q] ? ring_rd_data : INIT_SAMPLE;

	always_comb begin
		sum_d = sum_q;
		if (ring_we) begin
			sum_d = sum_q + SUM_W'(sample_ch.data.voltage_sample) - SUM_W'(old_sample);
		end
	end

	bvac_ram #(
		.WIDTH (16),
		.DEPTH (WINDOW_DEPTH)
	) u_ring (
		.clk     (clk),
		.we      (ring_we),
		.wr_addr (idx_q),
		.wr_data (sample_ch.data.voltage_sample),
		.rd_addr (idx_d),
		.rd_data (ring_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= SUM_RESET;
			valid_q <= '0;
		end else begin
			idx_q <= idx_d;
			sum_q <= sum_d;
			if (ring_we) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			v_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sum_s1    <= sum_d;
			sample_s1 <= sample_ch.data.voltage_sample;
		end
	end

	// sum / 160 as (sum >> 5) / 5; only used below the saturation point
	assign sum_div32 = sum_s1[15:5];
	assign div5_prod = 27'(sum_div32) * 27'(DIV5_RECIP);

	always_comb begin
		if (sum_s1 >= SUM_W'(AVG_SAT_SUM)) begin
			avg = 8'd255;
		end else begin
			avg = div5_prod[DIV5_SHIFT +: 8];
		end

		lvl = (avg < low_thresh_q) ? LVL_ULTRA_LOW : LVL_LOW;
		if (avg > normal_thresh_q) begin
			lvl = LVL_NORMAL;
		end
		if (avg > high_thresh_q) begin
			lvl = LVL_HIGH;
		end
		if (avg > ultrahigh_thresh_q) begin
			lvl = LVL_ULTRA_HIGH;
		end
		if (status_override_q < NO_OVERRIDE) begin
			lvl = status_override_q;
		end

		setpoint = (sample_s1 > SETPOINT_OFFSET) ? sample_s1 - SETPOINT_OFFSET : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.average_voltage  <= avg;
			out_q.battery_level    <= lvl;
			out_q.voltage_setpoint <= setpoint;
		end
	end

	assign result_ch.valid = out_v_q;
	assign result_ch.data  = out_q;

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(idx_q) < WINDOW_DEPTH)
		else $error("write index beyond window");

	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !sample_ch.data.hold |=> idx_q != $past(idx_q))
		else $error("write index did not advance");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_MAX)
		else $error("window sum out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !s1_move |=> v_s1 && $stable(sum_s1) && $stable(sample_s1))
		else $error("stage 1 word lost while stalled");

	a_idle_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!ring_we |=> $stable(sum_q))
		else $error("window sum changed without a ring write");

endmodule
